// File: design/indexed_list_store_macros.svh
// Assertion macros used by the checker of the list store.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef INDEXED_LIST_STORE_MACROS_SVH
`define INDEXED_LIST_STORE_MACROS_SVH

// Same-cycle implication.
`define ILS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ILS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/ils_pkg.sv
`timescale 1ns / 1ps

package ils_pkg;

	localparam int ILS_DEPTH     = 16;
	localparam int ILS_WORD_BITS = 32;

	localparam int OP_BITS     = 3;
	localparam int POS_BITS    = 5;
	localparam int ITEM_BITS   = 32;
	localparam int LEN_BITS    = 5;
	localparam int STATUS_BITS = 2;

	typedef logic [OP_BITS-1:0] op_code_t;

	localparam op_code_t OP_APPEND  = 3'd0;
	localparam op_code_t OP_INSERT  = 3'd1;
	localparam op_code_t OP_ERASE   = 3'd2;
	localparam op_code_t OP_REVERSE = 3'd3;
	localparam op_code_t OP_READ    = 3'd4;
	localparam op_code_t OP_CLEAR   = 3'd5;

	typedef logic [STATUS_BITS-1:0] status_t;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_RANGE = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic shift;
		logic drain;
		logic put;
		logic cap_read;
		logic rd_lo;
		logic rd_hi;
		logic wr_lo;
		logic wr_hi;
	} ils_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		status_t st;
		logic    shift_need;
		logic    rev_need;
		logic    cur_last;
		logic    rev_more;
		logic    dir_up;
	} ils_stat_t;

endpackage

// File: design/ils_ram.sv
`timescale 1ns / 1ps

module ils_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/ils_ctrl.sv
`timescale 1ns / 1ps

module ils_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ils_pkg::op_code_t operation,
	input  ils_pkg::ils_stat_t stat,
	output ils_pkg::ils_cmd_t cmd,
	output logic              busy,
	output logic              done
);

	import ils_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SHIFT,
		S_DRAIN,
		S_PUT,
		S_RD_WAIT,
		S_REV_RDLO,
		S_REV_RDHI,
		S_REV_WRLO,
		S_REV_WRHI,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;
	logic   done_q;
	logic   ok;

	assign ok = (stat.st == ST_OK);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (operation)
						OP_INSERT, OP_ERASE: begin
							state_d = (ok && stat.shift_need) ? S_SHIFT : S_DONE;
						end
						OP_REVERSE: begin
							state_d = stat.rev_need ? S_REV_RDLO : S_DONE;
						end
						OP_READ: begin
							state_d = ok ? S_RD_WAIT : S_DONE;
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_SHIFT: begin
				if (stat.cur_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = stat.dir_up ? S_PUT : S_DONE;
			end
			S_PUT:      state_d = S_DONE;
			S_RD_WAIT:  state_d = S_DONE;
			S_REV_RDLO: state_d = S_REV_RDHI;
			S_REV_RDHI: state_d = S_REV_WRLO;
			S_REV_WRLO: state_d = S_REV_WRHI;
			S_REV_WRHI: begin
				state_d = stat.rev_more ? S_REV_RDLO : S_DONE;
			end
			S_DONE:     state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.accept   = (state_q == S_IDLE) && start;
		cmd.shift    = (state_q == S_SHIFT);
		cmd.drain    = (state_q == S_DRAIN);
		cmd.put      = (state_q == S_PUT);
		cmd.cap_read = (state_q == S_RD_WAIT);
		cmd.rd_lo    = (state_q == S_REV_RDLO);
		cmd.rd_hi    = (state_q == S_REV_RDHI);
		cmd.wr_lo    = (state_q == S_REV_WRLO);
		cmd.wr_hi    = (state_q == S_REV_WRHI);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
			done_q  <= (state_d == S_DONE);
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

// File: design/ils_dp.sv
`timescale 1ns / 1ps

module ils_dp #(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ils_pkg::ils_cmd_t                    cmd,
	output ils_pkg::ils_stat_t                   stat,
	input  ils_pkg::op_code_t                    operation,
	input  logic [ils_pkg::POS_BITS-1:0]         position,
	input  logic [ils_pkg::ITEM_BITS-1:0]        item_word,
	output logic                                 mem_we,
	output logic [$clog2(DEPTH)-1:0]             mem_waddr,
	output logic [WORD_BITS-1:0]                 mem_wdata,
	output logic                                 mem_re,
	output logic [$clog2(DEPTH)-1:0]             mem_raddr,
	input  logic [WORD_BITS-1:0]                 mem_rdata,
	output logic [ils_pkg::ITEM_BITS-1:0]        read_word,
	output logic [ils_pkg::LEN_BITS-1:0]         length,
	output ils_pkg::status_t                     status
);

	import ils_pkg::*;

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = ((CW > POS_BITS) ? CW : POS_BITS) + 1;

	logic [CW-1:0]        count_q;
	logic [AW-1:0]        cur_q;
	logic [AW-1:0]        end_q;
	logic [AW-1:0]        wa_q;
	logic [AW-1:0]        pos_q;
	logic [WORD_BITS-1:0] word_q;
	logic [WORD_BITS-1:0] tmp_q;
	logic [ITEM_BITS-1:0] rword_q;
	status_t              status_q;
	logic                 dir_q;
	logic                 pend_q;

	logic [WORD_BITS-1:0] word_in;
	logic [CMPW-1:0]      pos_ext;
	logic [CMPW-1:0]      cnt_ext;
	logic [CMPW-1:0]      cnt_dec;
	logic [AW-1:0]        pos_a;
	logic [AW-1:0]        pos_p1;
	logic [AW-1:0]        cnt_a;
	logic [AW-1:0]        cnt_m1;
	logic                 full;
	logic                 ok;
	logic                 shift_need;
	status_t              st;

	assign word_in = WORD_BITS'(item_word);
	assign pos_ext = CMPW'(position);
	assign cnt_ext = CMPW'(count_q);
	assign cnt_dec = cnt_ext - CMPW'(1);
	assign pos_a   = pos_ext[AW-1:0];
	assign pos_p1  = pos_a + AW'(1);
	assign cnt_a   = cnt_ext[AW-1:0];
	assign cnt_m1  = cnt_dec[AW-1:0];
	assign full    = (cnt_ext == CMPW'(DEPTH));

	// Outcome of the operation on the beat being offered.
	always_comb begin
		st         = ST_OK;
		shift_need = 1'b0;
		case (operation)
			OP_APPEND: begin
				if (full) begin
					st = ST_FULL;
				end
			end
			OP_INSERT: begin
				if (pos_ext > cnt_ext) begin
					st = ST_RANGE;
				end else if (full) begin
					st = ST_FULL;
				end
				shift_need = (pos_ext < cnt_ext);
			end
			OP_ERASE: begin
				if (pos_ext >= cnt_ext) begin
					st = ST_RANGE;
				end
				shift_need = ((pos_ext + CMPW'(1)) < cnt_ext);
			end
			OP_READ: begin
				if (pos_ext >= cnt_ext) begin
					st = ST_RANGE;
				end
			end
			default: begin
				st = ST_OK;
			end
		endcase
	end

	assign ok = (st == ST_OK);

	assign stat.st         = st;
	assign stat.shift_need = shift_need;
	assign stat.rev_need   = (cnt_ext >= CMPW'(2));
	assign stat.cur_last   = (cur_q == end_q);
	assign stat.rev_more   = ((AW+1)'(cur_q) + (AW+1)'(2)) < (AW+1)'(end_q);
	assign stat.dir_up     = dir_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			pend_q <= cmd.shift;
			if (cmd.accept && ok) begin
				case (operation)
					OP_APPEND, OP_INSERT: count_q <= count_q + CW'(1);
					OP_ERASE:             count_q <= count_q - CW'(1);
					OP_CLEAR:             count_q <= '0;
					default:              count_q <= count_q;
				endcase
			end
		end
	end

	// Cursor and end mark: shift source and last source, or the low and
	// high ends of the pair being swapped.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pos_q    <= pos_a;
			word_q   <= word_in;
			status_q <= st;
			rword_q  <= '0;
			dir_q    <= (operation == OP_INSERT);
			case (operation)
				OP_INSERT: begin
					cur_q <= cnt_m1;
					end_q <= pos_a;
				end
				OP_ERASE: begin
					cur_q <= pos_p1;
					end_q <= cnt_m1;
				end
				default: begin
					cur_q <= '0;
					end_q <= cnt_m1;
				end
			endcase
		end
		if (cmd.shift) begin
			cur_q <= dir_q ? (cur_q - AW'(1)) : (cur_q + AW'(1));
			wa_q  <= dir_q ? (cur_q + AW'(1)) : (cur_q - AW'(1));
		end
		if (cmd.wr_hi) begin
			cur_q <= cur_q + AW'(1);
			end_q <= end_q - AW'(1);
		end
		if (cmd.rd_hi) begin
			tmp_q <= mem_rdata;
		end
		if (cmd.cap_read) begin
			rword_q <= ITEM_BITS'(mem_rdata);
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wa_q;
		mem_wdata = mem_rdata;
		if (cmd.accept && ok && (operation == OP_APPEND)) begin
			mem_we    = 1'b1;
			mem_waddr = cnt_a;
			mem_wdata = word_in;
		end else if (cmd.accept && ok && (operation == OP_INSERT) && !shift_need) begin
			mem_we    = 1'b1;
			mem_waddr = pos_a;
			mem_wdata = word_in;
		end else if ((cmd.shift || cmd.drain) && pend_q) begin
			mem_we    = 1'b1;
			mem_waddr = wa_q;
			mem_wdata = mem_rdata;
		end else if (cmd.put) begin
			mem_we    = 1'b1;
			mem_waddr = pos_q;
			mem_wdata = word_q;
		end else if (cmd.wr_lo) begin
			mem_we    = 1'b1;
			mem_waddr = cur_q;
			mem_wdata = mem_rdata;
		end else if (cmd.wr_hi) begin
			mem_we    = 1'b1;
			mem_waddr = end_q;
			mem_wdata = tmp_q;
		end
	end

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = cur_q;
		if (cmd.accept && (operation == OP_READ)) begin
			mem_re    = 1'b1;
			mem_raddr = pos_a;
		end else if (cmd.shift || cmd.rd_lo) begin
			mem_re    = 1'b1;
			mem_raddr = cur_q;
		end else if (cmd.rd_hi) begin
			mem_re    = 1'b1;
			mem_raddr = end_q;
		end
	end

	assign read_word = rword_q;
	assign length    = cnt_ext[LEN_BITS-1:0];
	assign status    = status_q;

endmodule

// File: design/indexed_list_store.sv
// Ordered list of up to DEPTH words with append, insert, erase, reverse, read
// and clear. An operation beat is taken when start is high and busy is low;
// busy then stays high until the result beat has been shown. Each operation
// gives exactly one result beat, marked by done for a single cycle, and the
// receiver cannot stall it: read_word, length and status must be taken in that
// cycle. Time per operation is set by the one element memory, which has one
// write and one read port. Append, clear, the unused codes, an insert at the
// end of the list, an erase of the last word and any rejected operation go
// straight to the result beat; a read passes through a wait state for the
// memory read; an insert below the length shifts, drains and then puts the new
// word; an erase below the last word shifts and drains; and a reverse swaps
// each pair (each swap is read low, read high, write low, write high). Shifts
// move one element per cycle. Length counts the words held after the operation;
// read_word is zero for everything but a good read. The memory needs no clearing
// after reset, since only entries below the length are ever used.
`timescale 1ns / 1ps

module indexed_list_store #(
	parameter int DEPTH     = ils_pkg::ILS_DEPTH,
	parameter int WORD_BITS = ils_pkg::ILS_WORD_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  ils_pkg::op_code_t             operation,
	input  logic [ils_pkg::POS_BITS-1:0]  position,
	input  logic [ils_pkg::ITEM_BITS-1:0] item_word,
	output logic                          done,
	output logic [ils_pkg::ITEM_BITS-1:0] read_word,
	output logic [ils_pkg::LEN_BITS-1:0]  length,
	output ils_pkg::status_t              status
);

	import ils_pkg::*;

	localparam int AW = $clog2(DEPTH);

	ils_cmd_t             cmd;
	ils_stat_t            stat;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic                 mem_re;
	logic [AW-1:0]        mem_raddr;
	logic [WORD_BITS-1:0] mem_rdata;

	// The controller sequences each operation; the datapath owns the
	// element count, the cursors and the memory ports.
	ils_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

	ils_dp #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.operation (operation),
		.position  (position),
		.item_word (item_word),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.read_word (read_word),
		.length    (length),
		.status    (status)
	);

	// Element storage. Contents are undefined until written.
	ils_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

// File: design/ils_checker.sv
`timescale 1ns / 1ps
`include "indexed_list_store_macros.svh"

module ils_checker #(
	parameter int DEPTH = ils_pkg::ILS_DEPTH
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [ils_pkg::ITEM_BITS-1:0] read_word,
	input logic [ils_pkg::LEN_BITS-1:0]  length,
	input ils_pkg::status_t              status
);

	import ils_pkg::*;

	localparam logic [LEN_BITS-1:0] LEN_FULL = LEN_BITS'(DEPTH);

	`ILS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
	`ILS_ASSERT_NOW(a_done_busy, done, busy, "result beat shown while not busy")
	`ILS_ASSERT_NEXT(a_done_single, done, !done, "result beat longer than one cycle")
	`ILS_ASSERT_NOW(a_err_zero, done && (status != ST_OK), read_word == '0, "failed op gave data")
	`ILS_ASSERT_NOW(a_full_len, done && (status == ST_FULL), length == LEN_FULL, "full with bad length")

endmodule

bind indexed_list_store ils_checker #(.DEPTH(DEPTH)) u_ils_checker (.*);
